[hw/rtl/prtt_pkg.sv]
package prtt_pkg;

  // Table geometry
  localparam int ENTRIES  = 16;
  localparam int TAG_BITS = 32;

  // Stored tag width: tags arrive on 32-bit fields, so never more than that
  localparam int TAG_W = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int KEY_W     = 64;
  localparam int FIELD_W   = 32;
  localparam int STAMP_W   = 64;
  localparam int ACTIVE_W  = 5;
  localparam int S_DATA_W  = 128;
  localparam int M_DATA_W  = 136;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_FIND = 2'd1,
    OP_TAKE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  // Search token moving down the row of cells
  typedef struct packed {
    logic               vld;
    logic [KEY_W-1:0]   key;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [TAG_W-1:0]   hit_cmd;
    logic [TAG_W-1:0]   hit_ctx;
    logic [STAMP_W-1:0] hit_cre;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
  } tok_t;

  // Write-back command, broadcast to all cells
  typedef struct packed {
    logic               en;
    logic               set;
    logic               clr;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   cmd;
    logic [TAG_W-1:0]   ctx;
    logic [STAMP_W-1:0] cre;
  } wr_t;

endpackage

[hw/rtl/prtt_cell.sv]
module prtt_cell
  import prtt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] my_idx,
  input  logic             sel,
  input  wr_t              wr,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic               valid;
  logic [KEY_W-1:0]   key;
  logic [TAG_W-1:0]   cmd;
  logic [TAG_W-1:0]   ctx;
  logic [STAMP_W-1:0] cre;
  logic               match;
  tok_t               tok_next;

  // Slot storage, updated by the write-back beat
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel && wr.set) begin
      valid <= 1'b1;
    end else if (sel && wr.clr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.set) begin
      key <= wr.key;
      cmd <= wr.cmd;
      ctx <= wr.ctx;
      cre <= wr.cre;
    end
  end

  // Compare against the passing token; first hit and first free slot win
  assign match = valid && (key == tok_in.key);

  always_comb begin
    tok_next = tok_in;
    if (match && !tok_in.hit) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = my_idx;
      tok_next.hit_cmd = cmd;
      tok_next.hit_ctx = ctx;
      tok_next.hit_cre = cre;
    end
    if (!valid && !tok_in.free) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = my_idx;
    end
  end

  // Hand the token on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

[hw/rtl/prtt_ctrl.sv]
module prtt_ctrl
  import prtt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output tok_t                tok_first,
  input  tok_t                tok_last,
  output wr_t                 wr
);

  state_t             state;
  state_t             state_next;
  logic [1:0]         req_op;
  logic [KEY_W-1:0]   req_key;
  logic [TAG_W-1:0]   req_cmd;
  logic [TAG_W-1:0]   req_ctx;
  tok_t               res;
  logic [STAMP_W-1:0] counter;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  logic               accept;
  logic               commit;
  logic               do_set;
  logic               do_clr;
  status_t            status;
  logic [TAG_W-1:0]   f_cmd;
  logic [TAG_W-1:0]   f_ctx;
  logic [STAMP_W-1:0] f_cre;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (tok_last.vld) state_next = S_WRITE;
      S_WRITE: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    commit        = (state == S_WRITE) && (!m_axis_tvalid || m_axis_tready);
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= s_axis_tuser;
      req_key <= s_axis_tdata[KEY_W-1:0];
      req_cmd <= s_axis_tdata[KEY_W +: TAG_W];
      req_ctx <= s_axis_tdata[KEY_W+FIELD_W +: TAG_W];
    end
  end

  // Launch a search token into the first cell
  always_comb begin
    tok_first     = '0;
    tok_first.vld = accept;
    tok_first.key = s_axis_tdata[KEY_W-1:0];
  end

  // Capture the token leaving the last cell
  always_ff @(posedge clk) begin
    if (tok_last.vld) begin
      res <= tok_last;
    end
  end

  // Decide the outcome from the scan result
  always_comb begin
    status = ST_INVALID;
    f_cmd  = '0;
    f_ctx  = '0;
    f_cre  = '0;
    do_set = 1'b0;
    do_clr = 1'b0;
    unique case (req_op)
      OP_ADD: begin
        if (req_key == '0 || req_cmd == '0) begin
          status = ST_INVALID;
        end else if (res.hit) begin
          status = ST_EXISTS;
        end else if (!res.free) begin
          status = ST_FULL;
        end else begin
          status = ST_OK;
          do_set = 1'b1;
        end
      end
      OP_FIND, OP_TAKE: begin
        if (req_key == '0) begin
          status = ST_INVALID;
        end else if (res.hit) begin
          status = ST_OK;
          f_cmd  = res.hit_cmd;
          f_ctx  = res.hit_ctx;
          f_cre  = res.hit_cre;
          do_clr = (req_op == OP_TAKE);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: status = ST_INVALID;
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_set) begin
      count_next = count + 1'b1;
    end else if (do_clr && count != '0) begin
      count_next = count - 1'b1;
    end
  end

  // Write-back beat to the cells
  always_comb begin
    wr     = '0;
    wr.en  = commit;
    wr.set = do_set;
    wr.clr = do_clr;
    wr.idx = do_set ? res.free_idx : res.hit_idx;
    wr.key = req_key;
    wr.cmd = req_cmd;
    wr.ctx = req_ctx;
    wr.cre = counter + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      count   <= '0;
    end else if (commit) begin
      count <= count_next;
      if (do_set) begin
        counter <= counter + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tdata <= {ACTIVE_W'(count_next), f_cre, FIELD_W'(f_ctx), FIELD_W'(f_cmd),
                       status};
    end
  end

endmodule

[hw/rtl/pending_request_tag_table.sv]
// Channel   Dir  Beat fields (low bit first)
// s_axis    in   tdata: request_key[63:0], command_tag[95:64], context_tag[127:96]
//                tuser: req_type[1:0]
// m_axis    out  tdata: status[2:0], found_command[34:3], found_context[66:35],
//                found_created[130:67], active_entries[135:131]
//
// Each request is accepted, then its search token walks the row of slot cells,
// then the write-back commits the result and updates the slot.
// One request is in flight at a time.
// rst clears all slot valid bits, the creation counter and the occupancy count.
// A new request is taken while the previous result waits in the output register;
// a stalled output holds the write-back until the result register is free.
module pending_request_tag_table
  import prtt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // request_key, command_tag, context_tag
  input  logic [1:0]          s_axis_tuser,  // req_type
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata   // status, found_command, found_context,
                                             // found_created, active_entries
);

  tok_t tok [ENTRIES+1];
  wr_t  wr;

  prtt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .tok_first     (tok[0]),
    .tok_last      (tok[ENTRIES]),
    .wr            (wr)
  );

  // Row of slot cells; the search token moves one cell per cycle
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic sel;
    assign sel = wr.en && (wr.idx == IDX_W'(i));

    prtt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_idx  (IDX_W'(i)),
      .sel     (sel),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

endmodule

[tb/sv/pending_request_tag_table_tb.sv]
module pending_request_tag_table_tb;
  import prtt_pkg::*;

  // Encoding outside the defined operations
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int RANDOM_REQUESTS = 1620;
  localparam int QUIET_TAIL      = 150;
  localparam int HOLD_AT_RESULT  = 300;
  localparam int HOLD_CYCLES     = 300;

  // Result beat, laid out as on m_axis_tdata (highest field first)
  typedef struct packed {
    logic [ACTIVE_W-1:0] active;
    logic [STAMP_W-1:0]  created;
    logic [FIELD_W-1:0]  ctx;
    logic [FIELD_W-1:0]  cmd;
    logic [2:0]          status;
  } result_t;

  typedef struct {
    logic [1:0]         op;
    logic [KEY_W-1:0]   key;
    logic [FIELD_W-1:0] cmd;
    logic [FIELD_W-1:0] ctx;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;   // request_key, command_tag, context_tag
  logic [1:0]          s_axis_tuser;   // req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;   // status, found_command, found_context,
                                       // found_created, active_entries

  pending_request_tag_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the table
  bit                 tbl_valid   [ENTRIES];
  logic [KEY_W-1:0]   tbl_key     [ENTRIES];
  logic [FIELD_W-1:0] tbl_cmd     [ENTRIES];
  logic [FIELD_W-1:0] tbl_ctx     [ENTRIES];
  logic [STAMP_W-1:0] tbl_created [ENTRIES];
  logic [STAMP_W-1:0] stamp_count;
  int                 live_count;

  result_t   pending_results[$];
  stim_row_t stim_rows[$];
  result_t   seen_beat;
  result_t   due_beat;
  int        mismatches;
  int        results_checked;
  bit        idle_on;
  bit        in_hold;
  bit        hold_done;
  int        stall_left;
  bit        filling;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Apply one request to the shadow table and return the beat it should produce
  function automatic result_t apply_request(logic [1:0] op, logic [KEY_W-1:0] key,
                                            logic [FIELD_W-1:0] cmd_in,
                                            logic [FIELD_W-1:0] ctx_in);
    result_t            r;
    logic [FIELD_W-1:0] cmd;
    logic [FIELD_W-1:0] ctx;
    int                 hit;
    int                 free_slot;
    r = '0;
    cmd = FIELD_W'(cmd_in[TAG_W-1:0]);
    ctx = FIELD_W'(ctx_in[TAG_W-1:0]);
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key && hit < 0) hit = i;
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
    end
    case (op)
      OP_ADD: begin
        if (key == '0 || cmd == '0) begin
          r.status = ST_INVALID;
        end else if (hit >= 0) begin
          // duplicate wins over a full table
          r.status = ST_EXISTS;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          stamp_count += STAMP_W'(1);
          tbl_valid[free_slot]   = 1'b1;
          tbl_key[free_slot]     = key;
          tbl_cmd[free_slot]     = cmd;
          tbl_ctx[free_slot]     = ctx;
          tbl_created[free_slot] = stamp_count;
          live_count++;
          r.status = ST_OK;
        end
      end
      OP_FIND, OP_TAKE: begin
        if (key == '0) begin
          r.status = ST_INVALID;
        end else if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status  = ST_OK;
          r.cmd     = tbl_cmd[hit];
          r.ctx     = tbl_ctx[hit];
          r.created = tbl_created[hit];
          if (op == OP_TAKE) begin
            tbl_valid[hit]   = 1'b0;
            tbl_key[hit]     = '0;
            tbl_cmd[hit]     = '0;
            tbl_ctx[hit]     = '0;
            tbl_created[hit] = '0;
            if (live_count > 0) live_count--;
          end
        end
      end
      default: r.status = ST_INVALID;
    endcase
    r.active = ACTIVE_W'(live_count);
    return r;
  endfunction

  function automatic result_t typed_result(status_t st, logic [FIELD_W-1:0] cmd,
                                           logic [FIELD_W-1:0] ctx,
                                           logic [STAMP_W-1:0] created, int active);
    result_t r;
    r.status  = st;
    r.cmd     = cmd;
    r.ctx     = ctx;
    r.created = created;
    r.active  = ACTIVE_W'(active);
    return r;
  endfunction

  function automatic stim_row_t row(logic [1:0] op, logic [KEY_W-1:0] key,
                                    logic [FIELD_W-1:0] cmd, logic [FIELD_W-1:0] ctx,
                                    bit typed, result_t want);
    stim_row_t s;
    s.op    = op;
    s.key   = key;
    s.cmd   = cmd;
    s.ctx   = ctx;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // Key of a random occupied slot; caller makes sure one exists
  function automatic logic [KEY_W-1:0] pick_live_key();
    int i;
    i = $urandom_range(0, ENTRIES - 1);
    while (!tbl_valid[i]) i = (i + 1) % ENTRIES;
    return tbl_key[i];
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 3) == 0) begin
      k = KEY_W'($urandom_range(1, 40));
    end else begin
      k = {$urandom, $urandom};
      if (k == '0) k = KEY_W'(1);
    end
    return k;
  endfunction

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Offer one beat, wait for acceptance, then record what should come back
  task automatic issue_request(logic [1:0] op, logic [KEY_W-1:0] key,
                               logic [FIELD_W-1:0] cmd, logic [FIELD_W-1:0] ctx,
                               bit typed, result_t want);
    result_t predicted;
    if (idle_on && !in_hold && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ctx, cmd, key};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_request(op, key, cmd, ctx);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      seen_beat = result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %0h", $time,
                 m_axis_tdata);
        mismatches++;
      end else begin
        due_beat = pending_results.pop_front();
        compare_field("status", 64'(due_beat.status), 64'(seen_beat.status));
        compare_field("found_command", 64'(due_beat.cmd), 64'(seen_beat.cmd));
        compare_field("found_context", 64'(due_beat.ctx), 64'(seen_beat.ctx));
        compare_field("found_created", due_beat.created, seen_beat.created);
        compare_field("active_entries", 64'(due_beat.active), 64'(seen_beat.active));
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off to back up the input
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
        if (stall_left == 0) in_hold = 1'b0;
      end else if (!hold_done && results_checked >= HOLD_AT_RESULT) begin
        hold_done  = 1'b1;
        in_hold    = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Hang guard
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Request side
  initial begin
    logic [1:0]         op;
    logic [KEY_W-1:0]   key;
    logic [FIELD_W-1:0] cmd;
    logic [FIELD_W-1:0] ctx;
    int                 pick;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    mismatches      = 0;
    results_checked = 0;
    idle_on    = 1'b1;
    in_hold    = 1'b0;
    hold_done  = 1'b0;
    stall_left = 0;
    filling    = 1'b0;
    stamp_count = '0;
    live_count  = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_key[i]     = '0;
      tbl_cmd[i]     = '0;
      tbl_ctx[i]     = '0;
      tbl_created[i] = '0;
    end

    // Directed table: empty table, argument errors, extremes, fill to full
    stim_rows.push_back(row(OP_FIND, 64'd1, '0, '0, 1'b1,
                            typed_result(ST_NOT_FOUND, '0, '0, '0, 0)));
    stim_rows.push_back(row(OP_ADD, '0, 32'd1, 32'd1, 1'b1,
                            typed_result(ST_INVALID, '0, '0, '0, 0)));
    stim_rows.push_back(row(OP_ADD, 64'd5, '0, '1, 1'b1,
                            typed_result(ST_INVALID, '0, '0, '0, 0)));
    stim_rows.push_back(row(OP_TAKE, '0, '1, '1, 1'b1,
                            typed_result(ST_INVALID, '0, '0, '0, 0)));
    stim_rows.push_back(row(OP_RESERVED, 64'd7, 32'd1, 32'd1, 1'b1,
                            typed_result(ST_INVALID, '0, '0, '0, 0)));
    stim_rows.push_back(row(OP_ADD, '1, '1, '0, 1'b1,
                            typed_result(ST_OK, '0, '0, '0, 1)));
    stim_rows.push_back(row(OP_FIND, '1, '0, '0, 1'b1,
                            typed_result(ST_OK, '1, '0, 64'd1, 1)));
    stim_rows.push_back(row(OP_ADD, '1, 32'd9, 32'd9, 1'b1,
                            typed_result(ST_EXISTS, '0, '0, '0, 1)));
    stim_rows.push_back(row(OP_TAKE, '1, '0, '0, 1'b1,
                            typed_result(ST_OK, '1, '0, 64'd1, 0)));
    stim_rows.push_back(row(OP_FIND, '1, '0, '0, 1'b1,
                            typed_result(ST_NOT_FOUND, '0, '0, '0, 0)));
    for (int i = 0; i < ENTRIES; i++)
      stim_rows.push_back(row(OP_ADD, 64'h1000 + i, 32'd1 << i, ~(32'd1 << i), 1'b0, '0));
    stim_rows.push_back(row(OP_ADD, 64'h2000, 32'd1, 32'd1, 1'b1,
                            typed_result(ST_FULL, '0, '0, '0, ENTRIES)));
    stim_rows.push_back(row(OP_ADD, 64'h1000, 32'd1, 32'd1, 1'b1,
                            typed_result(ST_EXISTS, '0, '0, '0, ENTRIES)));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i])
      issue_request(stim_rows[i].op, stim_rows[i].key, stim_rows[i].cmd,
                    stim_rows[i].ctx, stim_rows[i].typed, stim_rows[i].want);

    // Random traffic: mostly well-formed add/find/take, swinging between empty and full
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - QUIET_TAIL) idle_on = 1'b0;
      if (live_count >= ENTRIES) filling = 1'b0;
      else if (live_count == 0) filling = 1'b1;
      else if ($urandom_range(0, 63) == 0) filling = !filling;

      key = fresh_key();
      cmd = $urandom;
      if (cmd == '0) cmd = 1;
      if ($urandom_range(0, 15) == 0) cmd = '1;
      ctx = ($urandom_range(0, 7) == 0) ? '0 : FIELD_W'($urandom);
      pick = $urandom_range(0, 99);

      if (pick < 10) begin
        // noise and malformed requests
        case ($urandom_range(0, 4))
          0: begin
            op  = 2'($urandom_range(0, 3));
            key = '0;
          end
          1: begin
            op  = OP_RESERVED;
            key = {$urandom, $urandom};
          end
          2: begin
            op  = OP_ADD;
            cmd = '0;
          end
          3: op = ($urandom_range(0, 1) == 0) ? OP_FIND : OP_TAKE;
          default: begin
            op = OP_ADD;
            if (live_count > 0) key = pick_live_key();
          end
        endcase
      end else begin
        pick = $urandom_range(0, 99);
        if (filling) op = (pick < 70) ? OP_ADD : (pick < 85) ? OP_FIND : OP_TAKE;
        else         op = (pick < 15) ? OP_ADD : (pick < 45) ? OP_FIND : OP_TAKE;
        if (op != OP_ADD) begin
          if (live_count > 0) key = pick_live_key();
          else op = OP_ADD;
        end
      end
      issue_request(op, key, cmd, ctx, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/prtt_pkg.sv
hw/rtl/prtt_cell.sv
hw/rtl/prtt_ctrl.sv
hw/rtl/pending_request_tag_table.sv
tb/sv/pending_request_tag_table_tb.sv
